FILE: design/mva_pkg.sv
// Shared types and constants of the MIDI voice allocator.
package mva_pkg;

    // Field widths of the event and result words
    localparam int CMD_W   = 3;
    localparam int CHAN_W  = 4;
    localparam int KEY_W   = 7;
    localparam int VAL_W   = 7;
    localparam int VOICE_W = 5;

    // Number of MIDI channels, each with its own sustain pedal
    localparam int CHANNELS = 16;

    // Event commands
    localparam logic [CMD_W-1:0] CMD_NOTE_ON    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUSTAIN    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ALL_OFF    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET_CTRL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FULL_RESET = 3'd5;

    // Result actions
    localparam logic ACT_STOP  = 1'b0;
    localparam logic ACT_START = 1'b1;

    // Percussion channel and its playable key range
    localparam logic [CHAN_W-1:0] PERC_CHAN = 4'd9;
    localparam logic [KEY_W-1:0]  PERC_LOW  = 7'd35;
    localparam logic [KEY_W-1:0]  PERC_HIGH = 7'd81;

    // Pedal values at or above this count as pedal down
    localparam logic [VAL_W-1:0] PEDAL_ON = 7'd64;

    // Operation broadcast to every voice cell
    typedef enum logic [2:0] {
        OP_NONE,
        OP_STOP,
        OP_START,
        OP_HOLD,
        OP_CLR_AGE
    } cell_op_t;

    // Which slots a stop scan looks for
    typedef enum logic [1:0] {
        HIT_NOTE,
        HIT_HELD,
        HIT_CHAN,
        HIT_ALL
    } hit_mode_t;

    // Control word from the sequencer to the cells
    typedef struct packed {
        cell_op_t             op;
        hit_mode_t            mode;
        logic [CHAN_W-1:0]    chan;
        logic [KEY_W-1:0]     key;
    } cell_ctrl_t;

endpackage

FILE: design/mva_in_if.sv
// Event channel: valid/ready handshake carrying one MIDI event word.
interface mva_in_if import mva_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [CHAN_W-1:0] channel;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic              double_voice;

    modport source (
        output valid, command, channel, key, value, double_voice,
        input  ready
    );

    modport sink (
        input  valid, command, channel, key, value, double_voice,
        output ready
    );
endinterface

FILE: design/mva_out_if.sv
// Result channel: valid/ready handshake carrying one voice action word.
interface mva_out_if import mva_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [VOICE_W-1:0] voice;
    logic               action;
    logic               second_part;
    logic [CHAN_W-1:0]  out_channel;
    logic [KEY_W-1:0]   out_key;
    logic [VAL_W-1:0]   velocity;
    logic               last;

    modport source (
        output valid, voice, action, second_part, out_channel, out_key, velocity, last,
        input  ready
    );

    modport sink (
        input  valid, voice, action, second_part, out_channel, out_key, velocity, last,
        output ready
    );
endinterface

FILE: design/mva_cell.sv
// One voice slot: slot state, scan match, and one stage of the oldest-slot search.
module mva_cell import mva_pkg::*; #(
    parameter int IDX_W    = 5,
    parameter int AGE_BITS = 32,
    parameter int INDEX    = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctrl_t          ctrl,
    input  logic [IDX_W-1:0]    sel,
    input  logic [AGE_BITS-1:0] new_age,
    input  logic                free_vld_in,
    input  logic [IDX_W-1:0]    free_idx_in,
    input  logic [AGE_BITS-1:0] free_age_in,
    input  logic                any_vld_in,
    input  logic [IDX_W-1:0]    any_idx_in,
    input  logic [AGE_BITS-1:0] any_age_in,
    output logic                free_vld_out,
    output logic [IDX_W-1:0]    free_idx_out,
    output logic [AGE_BITS-1:0] free_age_out,
    output logic                any_vld_out,
    output logic [IDX_W-1:0]    any_idx_out,
    output logic [AGE_BITS-1:0] any_age_out,
    output logic                hit
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic                active_reg, active_next;
    logic                held_reg, held_next;
    logic [CHAN_W-1:0]   chan_reg, chan_next;
    logic [KEY_W-1:0]    note_reg, note_next;
    logic [AGE_BITS-1:0] age_reg, age_next;

    logic                free_vld_reg, free_vld_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [AGE_BITS-1:0] free_age_reg, free_age_next;
    logic                any_vld_reg;
    logic [IDX_W-1:0]    any_idx_reg, any_idx_next;
    logic [AGE_BITS-1:0] any_age_reg, any_age_next;

    logic mine;
    logic chan_eq;
    logic note_eq;
    logic take_free;
    logic take_any;

    assign mine    = (sel == MY_IDX);
    assign chan_eq = (chan_reg == ctrl.chan);
    assign note_eq = (note_reg == ctrl.key);

    // Match this slot against the running stop scan
    always_comb
    begin
        case (ctrl.mode)
            HIT_NOTE: hit = active_reg && chan_eq && note_eq;
            HIT_HELD: hit = active_reg && chan_eq && held_reg;
            HIT_CHAN: hit = active_reg && chan_eq;
            HIT_ALL:  hit = active_reg;
            default:  hit = 1'b0;
        endcase
    end

    // Apply the broadcast operation to the slot state
    always_comb
    begin
        active_next = active_reg;
        held_next   = held_reg;
        chan_next   = chan_reg;
        note_next   = note_reg;
        age_next    = age_reg;
        case (ctrl.op)
            OP_STOP:
            begin
                if (mine)
                begin
                    active_next = 1'b0;
                    held_next   = 1'b0;
                    age_next    = new_age;
                end
            end
            OP_START:
            begin
                if (mine)
                begin
                    active_next = 1'b1;
                    held_next   = 1'b0;
                    chan_next   = ctrl.chan;
                    note_next   = ctrl.key;
                    age_next    = new_age;
                end
            end
            OP_HOLD:
            begin
                if (active_reg && chan_eq && note_eq)
                begin
                    held_next = 1'b1;
                end
            end
            OP_CLR_AGE:
            begin
                age_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Pass the oldest-so-far candidates on; a lower index keeps ties
    assign take_free = !active_reg && (!free_vld_in || (age_reg < free_age_in));
    assign take_any  = !any_vld_in || (age_reg < any_age_in);

    assign free_vld_next = free_vld_in || !active_reg;
    assign free_idx_next = take_free ? MY_IDX : free_idx_in;
    assign free_age_next = take_free ? age_reg : free_age_in;
    assign any_idx_next  = take_any ? MY_IDX : any_idx_in;
    assign any_age_next  = take_any ? age_reg : any_age_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            held_reg     <= 1'b0;
            chan_reg     <= '0;
            note_reg     <= '0;
            age_reg      <= '0;
            free_vld_reg <= 1'b0;
            any_vld_reg  <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            held_reg     <= held_next;
            chan_reg     <= chan_next;
            note_reg     <= note_next;
            age_reg      <= age_next;
            free_vld_reg <= free_vld_next;
            any_vld_reg  <= 1'b1;
        end
    end

    // Search payload needs no reset: the valid flags qualify it
    always_ff @(posedge clk)
    begin
        free_idx_reg <= free_idx_next;
        free_age_reg <= free_age_next;
        any_idx_reg  <= any_idx_next;
        any_age_reg  <= any_age_next;
    end

    assign free_vld_out = free_vld_reg;
    assign free_idx_out = free_idx_reg;
    assign free_age_out = free_age_reg;
    assign any_vld_out  = any_vld_reg;
    assign any_idx_out  = any_idx_reg;
    assign any_age_out  = any_age_reg;

endmodule

FILE: design/midi_voice_allocator.sv
// MIDI voice allocator: takes one MIDI event word at a time and answers with the
// stop and start words it causes, in order, the final one marked by last. The voice
// table is a row of VOICES cells. A note-on finds its slot by passing the
// oldest free and oldest overall candidates one cell per cycle down the row, and a
// double-voice note searches a second time; a stolen voice is stopped as it is
// picked, with no extra state. Note-off, pedal release, all-notes-off and full reset
// walk the row one slot per cycle while no stop word waits for the result register
// (full reset then clears the ages). Reset controllers, a pedal press and ignored
// events need no walk, and a held note-off only marks its note as held. A new word
// waits while the result register has not been taken.
module midi_voice_allocator import mva_pkg::*; #(
    parameter int VOICES   = 18,
    parameter int AGE_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    mva_in_if.sink    midi,
    mva_out_if.source result
);

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W = $clog2(VOICES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(VOICES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SEARCH,
        S_START,
        S_HOLD,
        S_CLEAR
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [CHAN_W-1:0]   chan_reg, chan_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    vel_reg, vel_next;
    logic                dbl_reg, dbl_next;
    logic                second_reg, second_next;
    hit_mode_t           mode_reg, mode_next;
    logic [IDX_W-1:0]    pick_reg, pick_next;
    logic [AGE_BITS-1:0] age_count_reg, age_count_next;
    logic [CHANNELS-1:0] pedal_reg, pedal_next;

    logic                out_valid_reg, out_valid_next;
    logic [VOICE_W-1:0]  out_voice_reg, out_voice_next;
    logic                out_action_reg, out_action_next;
    logic                out_second_reg, out_second_next;
    logic [CHAN_W-1:0]   out_chan_reg, out_chan_next;
    logic [KEY_W-1:0]    out_key_reg, out_key_next;
    logic [VAL_W-1:0]    out_vel_reg, out_vel_next;
    logic                out_last_reg, out_last_next;

    cell_ctrl_t          ctrl_w;
    logic [IDX_W-1:0]    sel_w;
    logic [AGE_BITS-1:0] new_age_w;
    logic                emit_w;
    logic                can_emit_w;
    logic                perc_skip_w;
    logic                pedal_up_w;
    logic [IDX_W-1:0]    cnt_idx_w;
    logic [VOICES-1:0]   hit_vec;
    logic [VOICES-1:0]   above_vec;
    logic                more_w;

    logic                free_vld_w [VOICES+1];
    logic [IDX_W-1:0]    free_idx_w [VOICES+1];
    logic [AGE_BITS-1:0] free_age_w [VOICES+1];
    logic                any_vld_w  [VOICES+1];
    logic [IDX_W-1:0]    any_idx_w  [VOICES+1];
    logic [AGE_BITS-1:0] any_age_w  [VOICES+1];

    // Head of the search row starts empty
    assign free_vld_w[0] = 1'b0;
    assign free_idx_w[0] = '0;
    assign free_age_w[0] = '0;
    assign any_vld_w[0]  = 1'b0;
    assign any_idx_w[0]  = '0;
    assign any_age_w[0]  = '0;

    // Row of voice cells
    for (genvar i = 0; i < VOICES; i++)
    begin : g_cell
        mva_cell #(
            .IDX_W    (IDX_W),
            .AGE_BITS (AGE_BITS),
            .INDEX    (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl_w),
            .sel          (sel_w),
            .new_age      (new_age_w),
            .free_vld_in  (free_vld_w[i]),
            .free_idx_in  (free_idx_w[i]),
            .free_age_in  (free_age_w[i]),
            .any_vld_in   (any_vld_w[i]),
            .any_idx_in   (any_idx_w[i]),
            .any_age_in   (any_age_w[i]),
            .free_vld_out (free_vld_w[i+1]),
            .free_idx_out (free_idx_w[i+1]),
            .free_age_out (free_age_w[i+1]),
            .any_vld_out  (any_vld_w[i+1]),
            .any_idx_out  (any_idx_w[i+1]),
            .any_age_out  (any_age_w[i+1]),
            .hit          (hit_vec[i])
        );

        // Slots beyond the scan position
        assign above_vec[i] = hit_vec[i] && (CNT_W'(i) > cnt_reg);
    end

    assign more_w      = |above_vec;
    assign cnt_idx_w   = cnt_reg[IDX_W-1:0];
    assign new_age_w   = age_count_reg + AGE_BITS'(1);
    assign can_emit_w  = !out_valid_reg || result.ready;
    assign perc_skip_w = (midi.channel == PERC_CHAN)
                         && ((midi.key < PERC_LOW) || (midi.key > PERC_HIGH));
    assign pedal_up_w  = (midi.value < PEDAL_ON);

    // Sequencer: next state, cell operation and result word
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        chan_next       = chan_reg;
        key_next        = key_reg;
        vel_next        = vel_reg;
        dbl_next        = dbl_reg;
        second_next     = second_reg;
        mode_next       = mode_reg;
        pick_next       = pick_reg;
        age_count_next  = age_count_reg;
        pedal_next      = pedal_reg;

        ctrl_w.op       = OP_NONE;
        ctrl_w.mode     = mode_reg;
        ctrl_w.chan     = chan_reg;
        ctrl_w.key      = key_reg;
        sel_w           = pick_reg;

        emit_w          = 1'b0;
        out_voice_next  = out_voice_reg;
        out_action_next = out_action_reg;
        out_second_next = out_second_reg;
        out_chan_next   = out_chan_reg;
        out_key_next    = out_key_reg;
        out_vel_next    = out_vel_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (midi.valid)
                begin
                    cmd_next    = midi.command;
                    chan_next   = midi.channel;
                    key_next    = midi.key;
                    vel_next    = midi.value;
                    dbl_next    = midi.double_voice;
                    second_next = 1'b0;
                    cnt_next    = '0;
                    case (midi.command)
                        CMD_NOTE_ON:
                        begin
                            if (!perc_skip_w)
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        CMD_NOTE_OFF:
                        begin
                            if (pedal_reg[midi.channel])
                            begin
                                state_next = S_HOLD;
                            end
                            else
                            begin
                                mode_next  = HIT_NOTE;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_SUSTAIN:
                        begin
                            pedal_next[midi.channel] = !pedal_up_w;
                            if (pedal_up_w)
                            begin
                                mode_next  = HIT_HELD;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_ALL_OFF:
                        begin
                            mode_next  = HIT_CHAN;
                            state_next = S_SCAN;
                        end
                        CMD_RESET_CTRL:
                        begin
                            pedal_next[midi.channel] = 1'b0;
                        end
                        CMD_FULL_RESET:
                        begin
                            pedal_next = '0;
                            mode_next  = HIT_ALL;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Walk the slots in order and stop each match
            S_SCAN:
            begin
                sel_w = cnt_idx_w;
                if (cnt_reg == CNT_END)
                begin
                    state_next = (cmd_reg == CMD_FULL_RESET) ? S_CLEAR : S_IDLE;
                end
                else if (hit_vec[cnt_idx_w])
                begin
                    if (can_emit_w)
                    begin
                        ctrl_w.op       = OP_STOP;
                        emit_w          = 1'b1;
                        out_voice_next  = VOICE_W'(cnt_idx_w);
                        out_action_next = ACT_STOP;
                        out_second_next = 1'b0;
                        out_chan_next   = '0;
                        out_key_next    = '0;
                        out_vel_next    = '0;
                        out_last_next   = !more_w;
                        age_count_next  = new_age_w;
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            // Let the candidates run down the row, then take free or steal
            S_SEARCH:
            begin
                sel_w = any_idx_w[VOICES];
                if (cnt_reg != CNT_END)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else if (free_vld_w[VOICES])
                begin
                    pick_next  = free_idx_w[VOICES];
                    state_next = S_START;
                end
                else if (can_emit_w)
                begin
                    ctrl_w.op       = OP_STOP;
                    emit_w          = 1'b1;
                    out_voice_next  = VOICE_W'(any_idx_w[VOICES]);
                    out_action_next = ACT_STOP;
                    out_second_next = 1'b0;
                    out_chan_next   = '0;
                    out_key_next    = '0;
                    out_vel_next    = '0;
                    out_last_next   = 1'b0;
                    age_count_next  = new_age_w;
                    pick_next       = any_idx_w[VOICES];
                    state_next      = S_START;
                end
            end

            // Start the chosen slot; a double voice searches again
            S_START:
            begin
                if (can_emit_w)
                begin
                    ctrl_w.op       = OP_START;
                    emit_w          = 1'b1;
                    out_voice_next  = VOICE_W'(pick_reg);
                    out_action_next = ACT_START;
                    out_second_next = second_reg;
                    out_chan_next   = chan_reg;
                    out_key_next    = key_reg;
                    out_vel_next    = vel_reg;
                    out_last_next   = !(dbl_reg && !second_reg);
                    age_count_next  = new_age_w;
                    if (dbl_reg && !second_reg)
                    begin
                        second_next = 1'b1;
                        cnt_next    = '0;
                        state_next  = S_SEARCH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_HOLD:
            begin
                ctrl_w.op  = OP_HOLD;
                state_next = S_IDLE;
            end

            S_CLEAR:
            begin
                ctrl_w.op  = OP_CLR_AGE;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Result register: load a new word or drop the taken one
        if (emit_w)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            second_reg    <= 1'b0;
            mode_reg      <= HIT_ALL;
            age_count_reg <= '0;
            pedal_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            second_reg    <= second_next;
            mode_reg      <= mode_next;
            age_count_reg <= age_count_next;
            pedal_reg     <= pedal_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Event and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        chan_reg       <= chan_next;
        key_reg        <= key_next;
        vel_reg        <= vel_next;
        dbl_reg        <= dbl_next;
        pick_reg       <= pick_next;
        out_voice_reg  <= out_voice_next;
        out_action_reg <= out_action_next;
        out_second_reg <= out_second_next;
        out_chan_reg   <= out_chan_next;
        out_key_reg    <= out_key_next;
        out_vel_reg    <= out_vel_next;
        out_last_reg   <= out_last_next;
    end

    assign midi.ready         = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.voice       = out_voice_reg;
    assign result.action      = out_action_reg;
    assign result.second_part = out_second_reg;
    assign result.out_channel = out_chan_reg;
    assign result.out_key     = out_key_reg;
    assign result.velocity    = out_vel_reg;
    assign result.last        = out_last_reg;

    // A new word never overwrites one still waiting
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit_w |-> (!out_valid_reg || result.ready))
        else $error("result word overwritten while stalled");

    // Every stop or start advances the age counter by one
    a_age_step: assert property (@(posedge clk) disable iff (!rst_n)
        emit_w |=> (age_count_reg == $past(age_count_reg) + AGE_BITS'(1)))
        else $error("age counter out of step with emitted words");

    // The search has reached the end of the row when it is read
    a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SEARCH) && (cnt_reg == CNT_END)) |-> any_vld_w[VOICES])
        else $error("slot search read before it reached the end of the row");

endmodule
